// File: rtl/avsc_pkg.sv
// avsc_pkg: shared types, register codes and constants of the sample count correction block
package avsc_pkg;

  // field widths of the channels
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned DIFF_W    = 32;
  localparam int unsigned WANTED_W  = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 31;

  // configuration register widths
  localparam int unsigned COEF_W = 16;
  localparam int unsigned THR_W  = 31;
  localparam int unsigned RATE_W = 18;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AUDIO_IS_MASTER      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_COEFFICIENT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOSYNC_LIMIT         = 3'd4;

  // configuration reset values
  localparam logic [COEF_W-1:0] COEF_RESET   = 16'd52016;
  localparam logic [THR_W-1:0]  THR_RESET    = 31'd389120;
  localparam logic [RATE_W-1:0] RATE_RESET   = 18'd48000;
  localparam logic [THR_W-1:0]  NOSYNC_RESET = 31'd167772160;

  // difference accumulator, signed Q15.24, saturating
  localparam int unsigned ACC_W = 40;
  localparam int unsigned SUM_W = ACC_W + 2;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // shared multiply-accumulate unit
  localparam int unsigned MAC_A_W   = 24;
  localparam int unsigned MAC_B_W   = 21;
  localparam int unsigned MAC_P_W   = MAC_A_W + MAC_B_W;
  localparam int unsigned MAC_ACC_W = 64;
  localparam int unsigned MAC_SH    = 24;

  // floor(x/10) = (x * DIV10_RECIP) >> DIV10_SHIFT, exact for x below 2^20
  localparam logic [MAC_B_W-1:0] DIV10_RECIP = 21'd1677722;
  localparam int unsigned        DIV10_SHIFT = 24;

  // fixed point of the difference
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned CMAG_W = 26;
  localparam int unsigned W_W    = 28;

  typedef struct packed {
    logic              audio_is_master;
    logic [COEF_W-1:0] average_coefficient;
    logic [THR_W-1:0]  correction_threshold;
    logic [RATE_W-1:0] source_rate;
    logic [THR_W-1:0]  nosync_limit;
  } cfg_t;

  typedef struct packed {
    logic               go;
    logic               clr;
    logic               hi;
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
  } mac_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACC_LO,
    ST_ACC_HI,
    ST_ACC_WAIT,
    ST_ACC_DONE,
    ST_AVG_MAG,
    ST_AVG_LO,
    ST_AVG_HI,
    ST_AVG_WAIT,
    ST_AVG_DONE,
    ST_COR_LO,
    ST_COR_HI,
    ST_COR_WAIT,
    ST_COR_DONE,
    ST_MIN_MUL,
    ST_MAX_MUL,
    ST_MIN_DONE,
    ST_MAX_DONE,
    ST_CLAMP,
    ST_OUT
  } seq_state_t;

endpackage

// File: rtl/avsc_if.sv
// avsc interfaces: input item, result item and configuration write channels

interface avsc_in_if import avsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FRAME_W-1:0]       frame_samples;
  logic signed [DIFF_W-1:0] clock_difference;
  logic                     difference_valid;

  modport source (output valid, output frame_samples, output clock_difference,
                  output difference_valid, input ready);
  modport sink (input valid, input frame_samples, input clock_difference,
                input difference_valid, output ready);
endinterface

interface avsc_out_if import avsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WANTED_W-1:0] wanted_samples;
  logic                corrected;

  modport source (output valid, output wanted_samples, output corrected, input ready);
  modport sink (input valid, input wanted_samples, input corrected, output ready);
endinterface

interface avsc_cfg_if import avsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/av_sync_sample_count_correction.sv
// av_sync_sample_count_correction: top level of the audio sync sample count correction
// Each decoded audio frame is one item: the frame's sample count and the audio-minus-master
// clock difference go in, the sample count to produce and a corrected flag come out, one
// result per item. The block works on one item at a time. The result is loaded into the
// output register when audio is master or the difference is dropped, while the averaging
// window fills, when the averaged difference stays below the threshold and when a
// correction is applied; the later paths pass more products through the single 24x21
// two-stage multiply-accumulate unit that every product uses. The block returns to idle
// once the result is loaded and only then takes the next item. A new item is accepted
// while the previous result still waits on the output register; a result that finds that
// register still full holds the block until it drains.
// Configuration writes are taken in every cycle and belong in idle periods.
module av_sync_sample_count_correction import avsc_pkg::*; #(
  parameter int unsigned AVERAGE_WINDOW = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  avsc_in_if.sink    in_ch,
  avsc_out_if.source out_ch,
  avsc_cfg_if.sink   cfg_ch
);

  cfg_t                 cfg;
  mac_req_t             mac_req;
  logic [MAC_ACC_W-1:0] mac_acc;

  // configuration registers
  avsc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // shared multiplier
  avsc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .acc   (mac_acc)
  );

  // sequencer
  avsc_seq #(
    .AVERAGE_WINDOW (AVERAGE_WINDOW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mac_req (mac_req),
    .mac_acc (mac_acc)
  );

endmodule

// File: rtl/avsc_cfg.sv
// avsc_cfg: configuration register file
module avsc_cfg import avsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  avsc_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  // writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // register writes by index, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.audio_is_master      <= 1'b0;
      cfg_r.average_coefficient  <= COEF_RESET;
      cfg_r.correction_threshold <= THR_RESET;
      cfg_r.source_rate          <= RATE_RESET;
      cfg_r.nosync_limit         <= NOSYNC_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_AUDIO_IS_MASTER:      cfg_r.audio_is_master      <= cfg_ch.data[0];
        REG_AVERAGE_COEFFICIENT:  cfg_r.average_coefficient  <= cfg_ch.data[COEF_W-1:0];
        REG_CORRECTION_THRESHOLD: cfg_r.correction_threshold <= cfg_ch.data[THR_W-1:0];
        REG_SOURCE_RATE:          cfg_r.source_rate          <= cfg_ch.data[RATE_W-1:0];
        REG_NOSYNC_LIMIT:         cfg_r.nosync_limit         <= cfg_ch.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/avsc_mac.sv
// avsc_mac: shared two-stage multiply-accumulate unit
module avsc_mac import avsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mac_req_t             req,
  output logic [MAC_ACC_W-1:0] acc
);

  logic [MAC_P_W-1:0]        prod_r;
  logic                      p_vld_r;
  logic                      p_clr_r;
  logic                      p_hi_r;
  logic [MAC_ACC_W-1:0]      acc_r;
  logic [MAC_P_W+MAC_SH-1:0] prod_sh;
  logic [MAC_ACC_W-1:0]      addend;
  logic [MAC_ACC_W-1:0]      base;

  // upper partial products land one chunk up
  assign prod_sh = {prod_r, {MAC_SH{1'b0}}};
  assign addend  = p_hi_r ? prod_sh[MAC_ACC_W-1:0] : MAC_ACC_W'(prod_r);
  assign base    = p_clr_r ? '0 : acc_r;
  assign acc     = acc_r;

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= req.go;
    end
  end

  // product stage and accumulate stage
  always_ff @(posedge clk) begin
    if (req.go) begin
      prod_r  <= req.a * req.b;
      p_clr_r <= req.clr;
      p_hi_r  <= req.hi;
    end
    if (p_vld_r) begin
      acc_r <= base + addend;
    end
  end

endmodule

// File: rtl/avsc_seq.sv
// avsc_seq: sequencer and datapath registers for one frame's correction
module avsc_seq import avsc_pkg::*; #(
  parameter int unsigned AVERAGE_WINDOW = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  avsc_in_if.sink              in_ch,
  avsc_out_if.source           out_ch,
  output mac_req_t             mac_req,
  input  logic [MAC_ACC_W-1:0] mac_acc
);

  localparam int unsigned CNT_W = $clog2(AVERAGE_WINDOW + 1);

  seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [FRAME_W-1:0]       n_r, n_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic                     dvalid_r, dvalid_nxt;
  logic [DIFF_W-1:0]        dmag_r, dmag_nxt;
  logic [ACC_W-1:0]         mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [W_W-1:0]    w_r, w_nxt;
  logic [WANTED_W-1:0]      lo_r, lo_nxt;
  logic [WANTED_W-1:0]      hi_r, hi_nxt;
  logic [WANTED_W-1:0]      res_w_r, res_w_nxt;
  logic                     res_c_r, res_c_nxt;
  logic [WANTED_W-1:0]      out_w_r, out_w_nxt;
  logic                     out_c_r, out_c_nxt;

  logic [DIFF_W-1:0]        dmag_w;
  logic [ACC_W-1:0]         accmag_w;
  logic [ACC_W-1:0]         pm_w;
  logic signed [SUM_W-1:0]  sum_w;
  logic signed [ACC_W-1:0]  sat_w;
  logic [COEF_W:0]          one_minus_coef;
  logic [MAC_ACC_W-1:0]     thr_ext;
  logic [CMAG_W-1:0]        cmag_w;
  logic signed [W_W-1:0]    n_s;
  logic signed [W_W-1:0]    cmag_s;
  logic [FRAME_W+3:0]       x9_w;
  logic [FRAME_W+3:0]       x11_w;
  logic signed [W_W-1:0]    lo_s;
  logic signed [W_W-1:0]    hi_s;

  // magnitudes of the difference and of the accumulator
  assign dmag_w   = diff_r[DIFF_W-1] ? DIFF_W'(-diff_r) : DIFF_W'(diff_r);
  assign accmag_w = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  // coef*cum truncated toward zero, plus diff, saturated
  assign pm_w  = mac_acc[COEF_W +: ACC_W];
  assign sum_w = neg_r ? SUM_W'(diff_r) - $signed({2'b00, pm_w})
                       : SUM_W'(diff_r) + $signed({2'b00, pm_w});
  always_comb begin
    if (sum_w > SUM_W'(ACC_MAX)) begin
      sat_w = ACC_MAX;
    end else if (sum_w < SUM_W'(ACC_MIN)) begin
      sat_w = ACC_MIN;
    end else begin
      sat_w = sum_w[ACC_W-1:0];
    end
  end

  // average test operands
  assign one_minus_coef = (COEF_W+1)'(1 << COEF_W) - (COEF_W+1)'(cfg.average_coefficient);
  assign thr_ext        = MAC_ACC_W'({cfg.correction_threshold, {COEF_W{1'b0}}});

  // correction term and wanted count before clamping
  assign cmag_w = mac_acc[FRAC_W +: CMAG_W];
  assign n_s    = $signed(W_W'(n_r));
  assign cmag_s = $signed(W_W'(cmag_w));

  // 9n and 11n for the clamp bounds
  assign x9_w  = (FRAME_W+4)'({n_r, 3'b000}) + (FRAME_W+4)'(n_r);
  assign x11_w = (FRAME_W+4)'({n_r, 3'b000}) + (FRAME_W+4)'({n_r, 1'b0})
               + (FRAME_W+4)'(n_r);
  assign lo_s  = $signed(W_W'(lo_r));
  assign hi_s  = $signed(W_W'(hi_r));

  // handshake outputs
  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.wanted_samples = out_w_r;
  assign out_ch.corrected      = out_c_r;

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    n_nxt         = n_r;
    diff_nxt      = diff_r;
    dvalid_nxt    = dvalid_r;
    dmag_nxt      = dmag_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    w_nxt         = w_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_w_nxt     = res_w_r;
    res_c_nxt     = res_c_r;
    out_w_nxt     = out_w_r;
    out_c_nxt     = out_c_r;
    mac_req       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          n_nxt      = in_ch.frame_samples;
          diff_nxt   = in_ch.clock_difference;
          dvalid_nxt = in_ch.difference_valid;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        dmag_nxt  = dmag_w;
        mag_nxt   = accmag_w;
        neg_nxt   = acc_r[ACC_W-1];
        res_w_nxt = WANTED_W'(n_r);
        res_c_nxt = 1'b0;
        if (cfg.audio_is_master) begin
          state_nxt = ST_OUT;
        end else if (!dvalid_r || dmag_w >= DIFF_W'(cfg.nosync_limit)) begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_ACC_LO;
        end
      end
      // |cum| * coef over two chunks
      ST_ACC_LO: begin
        mac_req.go  = 1'b1;
        mac_req.clr = 1'b1;
        mac_req.a   = mag_r[MAC_A_W-1:0];
        mac_req.b   = MAC_B_W'(cfg.average_coefficient);
        state_nxt   = ST_ACC_HI;
      end
      ST_ACC_HI: begin
        mac_req.go = 1'b1;
        mac_req.hi = 1'b1;
        mac_req.a  = MAC_A_W'(mag_r[ACC_W-1:MAC_A_W]);
        mac_req.b  = MAC_B_W'(cfg.average_coefficient);
        state_nxt  = ST_ACC_WAIT;
      end
      ST_ACC_WAIT: begin
        state_nxt = ST_ACC_DONE;
      end
      ST_ACC_DONE: begin
        acc_nxt = sat_w;
        if (cnt_r < CNT_W'(AVERAGE_WINDOW)) begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_AVG_MAG;
        end
      end
      // |cum| * (1 - coef) against the threshold
      ST_AVG_MAG: begin
        mag_nxt   = accmag_w;
        state_nxt = ST_AVG_LO;
      end
      ST_AVG_LO: begin
        mac_req.go  = 1'b1;
        mac_req.clr = 1'b1;
        mac_req.a   = mag_r[MAC_A_W-1:0];
        mac_req.b   = MAC_B_W'(one_minus_coef);
        state_nxt   = ST_AVG_HI;
      end
      ST_AVG_HI: begin
        mac_req.go = 1'b1;
        mac_req.hi = 1'b1;
        mac_req.a  = MAC_A_W'(mag_r[ACC_W-1:MAC_A_W]);
        mac_req.b  = MAC_B_W'(one_minus_coef);
        state_nxt  = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        state_nxt = ST_AVG_DONE;
      end
      ST_AVG_DONE: begin
        if (mac_acc >= thr_ext) begin
          state_nxt = ST_COR_LO;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      // |diff| * rate, scaled down by the fraction bits
      ST_COR_LO: begin
        mac_req.go  = 1'b1;
        mac_req.clr = 1'b1;
        mac_req.a   = dmag_r[MAC_A_W-1:0];
        mac_req.b   = MAC_B_W'(cfg.source_rate);
        state_nxt   = ST_COR_HI;
      end
      ST_COR_HI: begin
        mac_req.go = 1'b1;
        mac_req.hi = 1'b1;
        mac_req.a  = MAC_A_W'(dmag_r[DIFF_W-1:MAC_A_W]);
        mac_req.b  = MAC_B_W'(cfg.source_rate);
        state_nxt  = ST_COR_WAIT;
      end
      ST_COR_WAIT: begin
        state_nxt = ST_COR_DONE;
      end
      ST_COR_DONE: begin
        w_nxt     = diff_r[DIFF_W-1] ? n_s - cmag_s : n_s + cmag_s;
        state_nxt = ST_MIN_MUL;
      end
      // clamp bounds 9n/10 and 11n/10 issued back to back
      ST_MIN_MUL: begin
        mac_req.go  = 1'b1;
        mac_req.clr = 1'b1;
        mac_req.a   = MAC_A_W'(x9_w);
        mac_req.b   = DIV10_RECIP;
        state_nxt   = ST_MAX_MUL;
      end
      ST_MAX_MUL: begin
        mac_req.go  = 1'b1;
        mac_req.clr = 1'b1;
        mac_req.a   = MAC_A_W'(x11_w);
        mac_req.b   = DIV10_RECIP;
        state_nxt   = ST_MIN_DONE;
      end
      ST_MIN_DONE: begin
        lo_nxt    = mac_acc[DIV10_SHIFT +: WANTED_W];
        state_nxt = ST_MAX_DONE;
      end
      ST_MAX_DONE: begin
        hi_nxt    = mac_acc[DIV10_SHIFT +: WANTED_W];
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        res_c_nxt = 1'b1;
        if (w_r < lo_s) begin
          res_w_nxt = lo_r;
        end else if (w_r > hi_s) begin
          res_w_nxt = hi_r;
        end else begin
          res_w_nxt = w_r[WANTED_W-1:0];
        end
        state_nxt = ST_OUT;
      end
      // hand the result to the output register once it is free
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_w_nxt     = res_w_r;
          out_c_nxt     = res_c_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item payload and working registers
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    diff_r   <= diff_nxt;
    dvalid_r <= dvalid_nxt;
    dmag_r   <= dmag_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    w_r      <= w_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    res_w_r  <= res_w_nxt;
    res_c_r  <= res_c_nxt;
    out_w_r  <= out_w_nxt;
    out_c_r  <= out_c_nxt;
  end

`ifndef SYNTHESIS
  // measurement count never passes the window
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(AVERAGE_WINDOW))
    else $error("measure count beyond window");

  // a correction is only reached with a full window
  a_clamp_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLAMP) |-> (cnt_r == CNT_W'(AVERAGE_WINDOW)))
    else $error("correction with window not full");

  // an accepted item goes straight to the check
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_CHECK))
    else $error("accepted item not checked");

  // clamp bounds are ordered
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLAMP) |-> (lo_r <= hi_r))
    else $error("clamp bounds out of order");
`endif

endmodule

// File: dv/tb_av_sync_sample_count_correction.sv
// testbench of the audio/video sync sample count correction block: directed table, random frames
module tb_av_sync_sample_count_correction;
  timeunit 1ns;
  timeprecision 1ps;
  import avsc_pkg::*;

  localparam int WINDOW = 20;
  localparam longint ACC_TOP = 64'sd549755813887;
  localparam longint ACC_BOT = -64'sd549755813888;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 100;
  localparam int SAT_PHASE = 2;
  localparam int SAT_ITEMS = 280;
  localparam int SETTLE_CYCLES = 30;
  localparam int REG_BITS [5] = '{1, COEF_W, THR_W, RATE_W, THR_W};

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // one line of the directed table: a frame repeated, or a register write
  typedef struct packed {
    row_kind_t              kind;
    logic [FRAME_W-1:0]     frame;
    logic [DIFF_W-1:0]      diff;
    logic                   dv;
    logic [7:0]             reps;
    logic                   typed;
    logic [WANTED_W-1:0]    exp_w;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DAT_W-1:0]   reg_data;
  } stim_row_t;

  typedef struct packed {
    logic [WANTED_W-1:0] wanted;
    logic                corrected;
  } count_result_t;

  logic clk = 1'b0;
  logic rst_n;

  avsc_in_if  in_ch();
  avsc_out_if out_ch();
  avsc_cfg_if cfg_ch();

  av_sync_sample_count_correction #(.AVERAGE_WINDOW(WINDOW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // mirrored registers and filter state
  logic              master_m;
  logic [COEF_W-1:0] coef_m;
  logic [THR_W-1:0]  thr_m;
  logic [RATE_W-1:0] rate_m;
  logic [THR_W-1:0]  nosync_m;
  longint            acc_m;
  int unsigned       meas_m;

  count_result_t owed_counts[$];
  int unsigned   fail_cnt = 0;
  bit            send_free = 1'b0;
  bit            ready_free = 1'b0;
  bit            run_neg = 1'b0;
  int unsigned   stall_left = 0;

  // expected sample count for one frame, advances the filter state
  function automatic count_result_t correct_count(logic [FRAME_W-1:0] n,
                                                  logic signed [DIFF_W-1:0] d, logic dv);
    count_result_t res;
    longint diff, dmag, amag, pm, sum, cmag, w, lo, hi;
    res.wanted = WANTED_W'(n);
    res.corrected = 1'b0;
    diff = longint'(d);
    dmag = (diff < 0) ? -diff : diff;
    if (!master_m) begin
      if (dv && dmag < longint'(nosync_m)) begin
        // exponential accumulate, magnitude truncated, sum saturated
        amag = (acc_m < 0) ? -acc_m : acc_m;
        pm = (amag * longint'(coef_m)) >>> 16;
        sum = diff + ((acc_m < 0) ? -pm : pm);
        if (sum > ACC_TOP) sum = ACC_TOP;
        if (sum < ACC_BOT) sum = ACC_BOT;
        acc_m = sum;
        amag = (acc_m < 0) ? -acc_m : acc_m;
        if (meas_m < WINDOW) begin
          meas_m++;
        end else if (amag * (65536 - longint'(coef_m)) >= (longint'(thr_m) <<< 16)) begin
          // correction toward the master clock, clamped to 90..110 percent
          cmag = (dmag * longint'(rate_m)) >>> 24;
          w = longint'(n) + ((diff < 0) ? -cmag : cmag);
          lo = longint'(n) * 90 / 100;
          hi = longint'(n) * 110 / 100;
          if (w < lo) w = lo;
          if (w > hi) w = hi;
          res.wanted = WANTED_W'(w);
          res.corrected = 1'b1;
        end
      end else begin
        acc_m = 0;
        meas_m = 0;
      end
    end
    return res;
  endfunction

  function automatic int unsigned idle_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      1: return FRAME_W'($urandom_range(0, 200));
      default: return FRAME_W'($urandom);
    endcase
  endfunction

  function automatic stim_row_t frame_row(int n, longint d, bit dv, int reps);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.frame = FRAME_W'(n);
    r.diff = DIFF_W'(d);
    r.dv = dv;
    r.reps = 8'(reps);
    return r;
  endfunction

  // frames whose count passes through untouched
  function automatic stim_row_t plain_row(int n, longint d, bit dv, int reps);
    stim_row_t r;
    r = frame_row(n, d, dv, reps);
    r.typed = 1'b1;
    r.exp_w = WANTED_W'(n);
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, longint data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_data = CFG_DAT_W'(data);
    return r;
  endfunction

  // stop sending, let every owed result out and the block settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (owed_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_AUDIO_IS_MASTER:      master_m = data[0];
      REG_AVERAGE_COEFFICIENT:  coef_m = data[COEF_W-1:0];
      REG_CORRECTION_THRESHOLD: thr_m = data[THR_W-1:0];
      REG_SOURCE_RATE:          rate_m = data[RATE_W-1:0];
      REG_NOSYNC_LIMIT:         nosync_m = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_frame(logic [FRAME_W-1:0] n, logic [DIFF_W-1:0] d, logic dv,
                            bit typed, count_result_t typed_res);
    count_result_t res;
    int unsigned gap;
    in_ch.valid            <= 1'b1;
    in_ch.frame_samples    <= n;
    in_ch.clock_difference <= d;
    in_ch.difference_valid <= dv;
    do @(posedge clk); while (!in_ch.ready);
    res = correct_count(n, d, dv);
    owed_counts.push_back(typed ? typed_res : res);
    gap = idle_gap(send_free);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random frame: mostly runs of same-sign differences near the threshold
  task automatic send_random();
    logic [DIFF_W-1:0] d;
    logic dv;
    longint span, mag;
    int unsigned r;
    r = $urandom_range(0, 99);
    dv = 1'b1;
    span = 4 * longint'(thr_m) + 4096;
    if (span > longint'(nosync_m) + 64) span = longint'(nosync_m) + 64;
    if (span > 64'sh7FFF_FFFF) span = 64'sh7FFF_FFFF;
    if ($urandom_range(0, 29) == 0) run_neg = ~run_neg;
    if (r < 3) begin
      dv = 1'b0;
      d = $urandom;
    end else if (r < 6) begin
      d = $urandom;
    end else begin
      if (r < 9) mag = longint'(nosync_m) + longint'($urandom_range(0, 2)) - 1;
      else mag = longint'($urandom_range(0, 32'(span)));
      if (mag < 0) mag = 0;
      if (mag > 64'sh7FFF_FFFF) mag = 64'sh7FFF_FFFF;
      d = run_neg ? DIFF_W'(-mag) : DIFF_W'(mag);
    end
    send_frame(pick_frame(), d, dv, 1'b0, '0);
  endtask

  // result side: random stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left <= idle_gap(ready_free);
    end
  end

  // compare each accepted result with the oldest owed one
  always @(posedge clk) begin
    count_result_t exp_r;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (owed_counts.size() == 0) begin
        $error("unexpected result: wanted_samples %0d corrected %0d",
               out_ch.wanted_samples, out_ch.corrected);
        fail_cnt++;
      end else begin
        exp_r = owed_counts.pop_front();
        if (out_ch.wanted_samples !== exp_r.wanted) begin
          $error("wanted_samples: expected %0d, got %0d", exp_r.wanted, out_ch.wanted_samples);
          fail_cnt++;
        end
        if (out_ch.corrected !== exp_r.corrected) begin
          $error("corrected: expected %0d, got %0d", exp_r.corrected, out_ch.corrected);
          fail_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t dir_tab[$];
    logic [CFG_DAT_W-1:0] vals [5];
    in_ch.valid = 1'b0;
    in_ch.frame_samples = '0;
    in_ch.clock_difference = '0;
    in_ch.difference_valid = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    master_m = 1'b0;
    coef_m = COEF_RESET;
    thr_m = THR_RESET;
    rate_m = RATE_RESET;
    nosync_m = NOSYNC_RESET;
    acc_m = 0;
    meas_m = 0;

    dir_tab = '{
      plain_row(0, 0, 1'b1, 1),                         // zero frame, window starts
      plain_row(65535, 32'h7FFF_FFFF, 1'b1, 1),         // largest difference drops
      plain_row(65535, 32'h8000_0000, 1'b1, 1),         // most negative drops
      plain_row(1234, 32'h5555_AAAA, 1'b0, 1),          // undefined difference
      plain_row(100, 167772159, 1'b1, 1),               // just under the limit
      plain_row(100, -167772160, 1'b1, 1),              // exactly at the limit
      plain_row(480, 1000000, 1'b1, WINDOW),            // fill the window
      frame_row(480, 1000000, 1'b1, 2),                 // correction, clamped high
      frame_row(65535, 1000000, 1'b1, 1),
      frame_row(65535, -1000000, 1'b1, 1),
      frame_row(1000, -8000000, 1'b1, 4),               // clamped low
      frame_row(0, 5000000, 1'b1, 1),
      frame_row(1, -1, 1'b1, 1),
      reg_row(REG_SOURCE_RATE, 0),                      // zero rate: clamp only
      frame_row(5000, 2000000, 1'b1, 2),
      reg_row(REG_AUDIO_IS_MASTER, 1),                  // audio master passes through
      plain_row(777, 3000000, 1'b1, 1),
      plain_row(777, 32'h8000_0000, 1'b1, 1),
      plain_row(777, 0, 1'b0, 1),
      reg_row(REG_AUDIO_IS_MASTER, 0),                  // filter state kept
      frame_row(777, 3000000, 1'b1, 1),
      reg_row(3'd5, 32'h7FFF_FFFF),                     // indexes past the list ignored
      reg_row(3'd7, 0),
      frame_row(2000, -3000000, 1'b1, 1),
      reg_row(REG_SOURCE_RATE, RATE_RESET)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == ROW_REG) begin
        write_reg(dir_tab[k].reg_idx, dir_tab[k].reg_data);
      end else begin
        repeat (dir_tab[k].reps)
          send_frame(dir_tab[k].frame, dir_tab[k].diff, dir_tab[k].dv, dir_tab[k].typed,
                     {dir_tab[k].exp_w, 1'b0});
      end
    end

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: vals = '{0, COEF_RESET, THR_RESET, RATE_RESET, NOSYNC_RESET};
        1: vals = '{0, 0, 0, 192000, '1};
        SAT_PHASE: vals = '{0, 65535, 0, 1, '1};
        3: vals = '{0, 65535, '1, 18'h3FFFF, 0};
        4: vals = '{1, $urandom, $urandom, $urandom, $urandom};
        5: vals = '{0, 0, '1, 0, '1};
        default: begin
          vals = '{($urandom_range(0, 7) == 0), $urandom,
                   ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1 << 22) : $urandom,
                   $urandom_range(1, 192000), $urandom_range(1 << 22, 32'h7FFF_FFFF)};
          // stray bits above the narrower registers
          for (int k = 0; k < 5; k++)
            if ($urandom_range(0, 3) == 0) vals[k] |= CFG_DAT_W'($urandom) << REG_BITS[k];
        end
      endcase
      for (int k = 0; k < 5; k++) write_reg(CFG_IDX_W'(k), vals[k]);
      send_free = ($urandom_range(0, 3) == 0);
      ready_free = ($urandom_range(0, 3) == 0);

      // drive the accumulator into both saturation limits
      if (p == SAT_PHASE) begin
        repeat (SAT_ITEMS)
          send_frame(pick_frame(), DIFF_W'(64'sh7FFF_FFFE - longint'($urandom_range(0, 1000))),
                     1'b1, 1'b0, '0);
        send_frame(pick_frame(), $urandom, 1'b0, 1'b0, '0);
        repeat (SAT_ITEMS)
          send_frame(pick_frame(),
                     DIFF_W'(-(64'sh7FFF_FFFE - longint'($urandom_range(0, 1000)))),
                     1'b1, 1'b0, '0);
      end

      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 79) == 0) wait_drained();
        send_random();
      end
    end

    wait_drained();
    if (fail_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/avsc_pkg.sv
rtl/avsc_if.sv
rtl/avsc_cfg.sv
rtl/avsc_mac.sv
rtl/avsc_seq.sv
rtl/av_sync_sample_count_correction.sv
dv/tb_av_sync_sample_count_correction.sv
